// ===== rtl/core/weighted_data_share_admission_core_defines.svh =====
// Assertion helpers for the weighted data share admission core
`ifndef WEIGHTED_DATA_SHARE_ADMISSION_CORE_DEFINES_SVH
`define WEIGHTED_DATA_SHARE_ADMISSION_CORE_DEFINES_SVH

// Same-cycle implication, reset aware
`define WDSA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("wdsa assertion failed");

// Next-cycle implication, reset aware
`define WDSA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("wdsa assertion failed");

`endif

// ===== rtl/core/wdsa_pkg.sv =====
// ----------------------------------------------------------------------------
// wdsa_pkg
// Types, widths and codes shared by the admission core modules.
// ----------------------------------------------------------------------------
package wdsa_pkg;

  localparam int NODE_SLOTS_DEF = 64;
  localparam int OP_W       = 2;
  localparam int IDX_W      = 6;
  localparam int IO_W       = 8;
  localparam int WGT_W      = 48;
  localparam int TOTAL_W    = 48;
  localparam int TOL_W      = 12;
  localparam int SUM_W      = 14;
  localparam int LIM_W      = 63;
  localparam int PROD_W     = TOTAL_W + IO_W;
  localparam int NUM_W      = PROD_W + TOL_W;
  localparam int FRAC_BITS  = 8;
  localparam int DEN_W      = SUM_W + FRAC_BITS;
  localparam int CNT_W      = $clog2(NUM_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  localparam logic [SUM_W-1:0] SUM_MAX   = '1;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(256);

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER = 2'd0,
    OP_UPDATE   = 2'd1,
    OP_CHECK    = 2'd2,
    OP_DEACT    = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL = 2'd0,
    CFG_TOL   = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_MUL1,
    S_MUL2,
    S_DIV,
    S_FIN,
    S_CLR
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clr;
    logic load;
    logic rd;
    logic upd;
    logic mul1;
    logic mul2;
    logic div_step;
    logic fin;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/core/wdsa_intf.sv =====
// ----------------------------------------------------------------------------
// wdsa channel interfaces
// Item, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface wdsa_item_if import wdsa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [IDX_W-1:0]        node_index;
  logic [IO_W-1:0]         io_weight;
  logic signed [WGT_W-1:0] delta;

  modport source (output valid, operation, node_index, io_weight, delta, input ready);
  modport sink   (input valid, operation, node_index, io_weight, delta, output ready);
endinterface

interface wdsa_result_if import wdsa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    allowed;
  logic [LIM_W-1:0]        node_limit;
  logic signed [WGT_W-1:0] node_weight_now;
  logic [SUM_W-1:0]        active_weight_sum;

  modport source (output valid, allowed, node_limit, node_weight_now, active_weight_sum,
                  input ready);
  modport sink   (input valid, allowed, node_limit, node_weight_now, active_weight_sum,
                  output ready);
endinterface

interface wdsa_cfg_if import wdsa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/wdsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// wdsa_ctrl
// Sequencer: table clear after reset, then read, table update, two
// multiplies, bit-serial divide, result.
// ----------------------------------------------------------------------------
module wdsa_ctrl import wdsa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLR: begin
        // zero one table slot per cycle
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.upd = 1'b1;
        state_d   = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // wait for the output register to free up
        if (stat_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/wdsa_dp.sv =====
// ----------------------------------------------------------------------------
// wdsa_dp
// Node table, active sum, limit arithmetic and result register.
// ----------------------------------------------------------------------------
module wdsa_dp import wdsa_pkg::*; #(
  parameter int NODE_SLOTS = NODE_SLOTS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output stat_t                   stat_o,
  // item payload
  input  logic [OP_W-1:0]         operation_i,
  input  logic [IDX_W-1:0]        node_index_i,
  input  logic [IO_W-1:0]         io_weight_i,
  input  logic signed [WGT_W-1:0] delta_i,
  // configuration writes
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  // result
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    allowed_o,
  output logic [LIM_W-1:0]        node_limit_o,
  output logic signed [WGT_W-1:0] node_weight_now_o,
  output logic [SUM_W-1:0]        active_weight_sum_o
);

  localparam int IW = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;

  // configuration
  logic [TOTAL_W-1:0] total_q;
  logic [TOL_W-1:0]   tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      tol_q   <= TOL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_TOTAL: total_q <= cfg_data_i[TOTAL_W-1:0];
        CFG_TOL:   tol_q   <= cfg_data_i[TOL_W-1:0];
        default:   ;
      endcase
    end
  end

  // captured item
  op_e                     op_q;
  logic [IDX_W-1:0]        idx_q;
  logic [IO_W-1:0]         io_q;
  logic signed [WGT_W-1:0] delta_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_e'(operation_i);
      idx_q   <= node_index_i;
      io_q    <= io_weight_i;
      delta_q <= delta_i;
    end
  end

  logic [IW-1:0] slot;
  logic          in_range;
  assign slot     = IW'(idx_q);
  assign in_range = 32'(idx_q) < NODE_SLOTS;

  // clearing pass address after reset
  logic [IW-1:0] clr_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
    end else if (cmd_i.clr) begin
      clr_idx_q <= clr_idx_q + IW'(1);
    end
  end

  assign stat_o.clr_last = (clr_idx_q == IW'(NODE_SLOTS - 1));

  // node table: weights, I/O weights and active bits in memory
  logic signed [WGT_W-1:0] w_mem [NODE_SLOTS];
  logic [IO_W-1:0]         io_mem [NODE_SLOTS];
  logic                    act_mem [NODE_SLOTS];
  logic signed [WGT_W-1:0] rd_w_q;
  logic [IO_W-1:0]         rd_io_q;
  logic                    rd_act_q;

  logic signed [WGT_W-1:0] w_new;
  logic [IO_W-1:0]         io_new;
  logic                    act_new;
  logic [SUM_W-1:0]        sum_q, sum_new;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      w_mem[clr_idx_q]   <= '0;
      io_mem[clr_idx_q]  <= '0;
      act_mem[clr_idx_q] <= 1'b0;
    end else if (cmd_i.upd && in_range) begin
      w_mem[slot]   <= w_new;
      io_mem[slot]  <= io_new;
      act_mem[slot] <= act_new;
    end
    if (cmd_i.rd) begin
      rd_w_q   <= w_mem[slot];
      rd_io_q  <= io_mem[slot];
      rd_act_q <= act_mem[slot];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (cmd_i.upd && in_range) begin
      sum_q <= sum_new;
    end
  end

  // table update for one item
  logic signed [WGT_W-1:0] old_w;
  logic [IO_W-1:0]         old_io;
  logic                    old_act;
  logic signed [WGT_W:0]   w_sum;
  logic [SUM_W-1:0]        sum_rm;
  logic [SUM_W:0]          sum_ad;

  always_comb begin
    old_w   = rd_w_q;
    old_io  = rd_io_q;
    old_act = rd_act_q;
    w_new   = old_w;
    io_new  = old_io;
    act_new = old_act;
    sum_new = sum_q;
    // old I/O weight leaves the sum, floor at zero
    sum_rm  = (sum_q > SUM_W'(old_io)) ? sum_q - SUM_W'(old_io) : '0;
    sum_ad  = {1'b0, sum_rm} + (SUM_W + 1)'(io_q);
    w_sum   = {old_w[WGT_W-1], old_w} + {delta_q[WGT_W-1], delta_q};
    unique case (op_q)
      OP_REGISTER: begin
        io_new  = io_q;
        act_new = (io_q != '0);
        if (old_act) begin
          sum_new = sum_rm;
        end
        if (io_q != '0) begin
          // adds to the sum, reduced if the node was active, capped at the top
          if (!old_act) begin
            sum_ad = {1'b0, sum_q} + (SUM_W + 1)'(io_q);
          end
          sum_new = sum_ad[SUM_W] ? SUM_MAX : sum_ad[SUM_W-1:0];
        end
      end
      OP_UPDATE: begin
        io_new = io_q;
        // saturate to the signed weight range
        if (w_sum[WGT_W] != w_sum[WGT_W-1]) begin
          w_new = w_sum[WGT_W] ? {1'b1, {(WGT_W-1){1'b0}}} : {1'b0, {(WGT_W-1){1'b1}}};
        end else begin
          w_new = w_sum[WGT_W-1:0];
        end
      end
      OP_CHECK: begin
        io_new = io_q;
      end
      OP_DEACT: begin
        if (old_act) begin
          act_new = 1'b0;
          sum_new = sum_rm;
        end
      end
      default: ;
    endcase
  end

  // weight and I/O weight seen by the limit calculation
  logic signed [WGT_W-1:0] cur_w_q;
  logic [IO_W-1:0]         cur_io_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      cur_w_q  <= w_new;
      cur_io_q <= io_new;
    end
  end

  // limit = ceil(total * io * tol / (max(sum,1) * 256)), restoring divide
  logic [PROD_W-1:0] prod_q;
  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DEN_W:0]    rem_sh;
  logic              ge;

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      prod_q <= PROD_W'(total_q * cur_io_q);
    end
    if (cmd_i.mul2) begin
      num_q <= NUM_W'(prod_q * tol_q);
      den_q <= {((sum_q == '0) ? SUM_W'(1) : sum_q), {FRAC_BITS{1'b0}}};
      rem_q <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
      num_q <= {num_q[NUM_W-2:0], ge};
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  assign stat_o.div_last = (cnt_q == CNT_W'(NUM_W - 1));

  // result register
  logic [LIM_W-1:0] limit;
  logic             admit;

  assign limit = num_q[LIM_W-1:0] + LIM_W'(rem_q != '0);
  assign admit = (op_q == OP_CHECK) &&
                 (cur_w_q[WGT_W-1] || (LIM_W'(cur_w_q) <= limit));

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      allowed_o           <= in_range && admit;
      node_limit_o        <= in_range ? limit : '0;
      node_weight_now_o   <= in_range ? cur_w_q : '0;
      active_weight_sum_o <= sum_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

endmodule

// ===== rtl/core/weighted_data_share_admission_core.sv =====
// An accepted item passes through read, table update, two multiplies and the
// bit-serial divider; no new item is taken until its result is registered.
// Configuration writes are taken in any cycle, ready is always high.
// Reset (rst_ni, async, low) clears the active sum and sets tolerance to 1.0;
// a clearing pass over all NODE_SLOTS slots (64 by default) then zeroes
// the node table, and no item is taken until it ends.
// ----------------------------------------------------------------------------
// weighted_data_share_admission_core
// Node table with I/O weight sum and per-node data weight admission limit.
// ----------------------------------------------------------------------------
`include "weighted_data_share_admission_core_defines.svh"

module weighted_data_share_admission_core import wdsa_pkg::*; #(
  parameter int NODE_SLOTS = NODE_SLOTS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  wdsa_item_if.sink    item_i,
  wdsa_result_if.source result_o,
  wdsa_cfg_if.sink     cfg_i
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_i.ready = 1'b1;

  wdsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  wdsa_dp #(
    .NODE_SLOTS (NODE_SLOTS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .operation_i         (item_i.operation),
    .node_index_i        (item_i.node_index),
    .io_weight_i         (item_i.io_weight),
    .delta_i             (item_i.delta),
    .cfg_we_i            (cfg_i.valid),
    .cfg_index_i         (cfg_i.index),
    .cfg_data_i          (cfg_i.data),
    .out_valid_o         (result_o.valid),
    .out_ready_i         (result_o.ready),
    .allowed_o           (result_o.allowed),
    .node_limit_o        (result_o.node_limit),
    .node_weight_now_o   (result_o.node_weight_now),
    .active_weight_sum_o (result_o.active_weight_sum)
  );

  // checks
  `WDSA_ASSERT_IMP(a_cmd_onehot, clk_i, rst_ni, 1'b1, $onehot0(cmd))
  `WDSA_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, cmd.div_step, !item_i.ready)
  `WDSA_ASSERT_IMP(a_result_from_fin, clk_i, rst_ni, $rose(result_o.valid), $past(cmd.fin))

endmodule
